// File: src/cmpl_pkg.sv
// colormap piecewise-linear unit: shared types and constants
// used by cmpl_front, cmpl_back and the top level; no dependencies
`timescale 1ns / 1ps

package cmpl_pkg;

   localparam int DATA_W     = 16;
   localparam int IDX_W      = 4;
   localparam int CFG_W      = 5;
   localparam int COLOR_W    = 3 * DATA_W;
   localparam int ENTRY_W    = DATA_W + COLOR_W;
   localparam int NUM_CHAN   = 3;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int DIV_CNT_W  = $clog2(DATA_W);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   localparam logic [CFG_W-1:0] SAMPLE_COUNT_RESET = CFG_W'(2);

   typedef struct packed {
      logic                is_map;
      logic                wr_en;
      logic [IDX_W-1:0]    wr_idx;
      logic [DATA_W-1:0]   position;
      logic [COLOR_W-1:0]  color;
      logic [DATA_W-1:0]   sample;
   } item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PFIRST,
      S_CLAMP,
      S_SRCH,
      S_LO,
      S_HI,
      S_MUL,
      S_SUM,
      S_DIV,
      S_DONE
   } state_type;

endpackage

// File: src/cmpl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module cmpl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/cmpl_front.sv
// front end: accepts request transactions, classifies them, queues them
// depends on cmpl_pkg
`timescale 1ns / 1ps

module cmpl_front #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_opcode,
   input  logic [cmpl_pkg::IDX_W-1:0] req_entry_index,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_position,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_hue,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_saturation,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_brightness,
   input  logic [cmpl_pkg::DATA_W-1:0] req_sample_value,
   output logic                       item_valid,
   output cmpl_pkg::item_type         item,
   input  logic                       item_pop
);

   localparam int IDX_CMP_W = cmpl_pkg::IDX_W + 8;

   cmpl_pkg::item_type q_ff [2];
   cmpl_pkg::item_type new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      new_item.is_map   = (req_opcode == cmpl_pkg::OP_MAP);
      new_item.wr_en    = (req_opcode == cmpl_pkg::OP_WRITE) &&
                          (IDX_CMP_W'(req_entry_index) < IDX_CMP_W'(MAX_ENTRIES));
      new_item.wr_idx   = req_entry_index;
      new_item.position = req_entry_position;
      new_item.color    = {req_entry_hue, req_entry_saturation, req_entry_brightness};
      new_item.sample   = req_sample_value;
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ item_pop;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !item_pop) |=> (count_ff == 2'd2))
      else $error("full queue lost an entry");

endmodule

// File: src/cmpl_back.sv
// back end: table writes, bisection search, interpolation and division
// depends on cmpl_pkg and cmpl_ram
`timescale 1ns / 1ps

module cmpl_back #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [cmpl_pkg::CFG_W-1:0]  sample_count,
   input  logic                        item_valid,
   input  cmpl_pkg::item_type          item,
   output logic                        item_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cmpl_pkg::DATA_W-1:0] rsp_out_hue,
   output logic [cmpl_pkg::DATA_W-1:0] rsp_out_saturation,
   output logic [cmpl_pkg::DATA_W-1:0] rsp_out_brightness,
   output logic [cmpl_pkg::IDX_W-1:0]  rsp_interval_index,
   output logic                        rsp_was_clamped
);

   localparam int ADDR_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 2);
   localparam int DW     = cmpl_pkg::DATA_W;
   localparam int NC     = cmpl_pkg::NUM_CHAN;
   localparam int SAT_W  = CNT_W + cmpl_pkg::CFG_W;

   cmpl_pkg::state_type state_ff, state_in;

   logic                          ram_we;
   logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
   logic [cmpl_pkg::ENTRY_W-1:0]  ram_rdata;
   logic [DW-1:0]                 rd_pos;
   logic [cmpl_pkg::COLOR_W-1:0]  rd_color;
   logic [ADDR_W+cmpl_pkg::IDX_W-1:0] waddr_wide;

   logic [SAT_W-1:0]  n_wide;
   logic [CNT_W-1:0]  n_sat;
   logic [CNT_W-1:0]  n_ff;
   logic [DW-1:0]     x_ff, x_in;
   logic              clamp_ff, clamp_in;
   logic [DW-1:0]     pfirst_ff, plast_ff;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in;
   logic [CNT_W:0]    sum_cur, sum_next;
   logic [CNT_W-1:0]  mid_cur, mid_next, gap_next;
   logic              ge_cur;
   logic [DW-1:0]     plo_ff;
   logic [cmpl_pkg::COLOR_W-1:0] clo_ff, chi_ff;
   logic [DW-1:0]     w_ff, wt_ff, t_ff, w_in, t_in;
   logic              degen;
   logic [cmpl_pkg::PROD_W-1:0] pa_ff [NC];
   logic [cmpl_pkg::PROD_W-1:0] pb_ff [NC];
   logic [cmpl_pkg::ACC_W-1:0]  acc    [NC];
   logic [DW-1:0]     rem_ff [NC];
   logic [DW-1:0]     quo_ff [NC];
   logic [DW:0]       shifted [NC];
   logic              fits [NC];
   logic [cmpl_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic              rsp_valid_ff;
   logic [DW-1:0]     res_ff [NC];
   logic [CNT_W+cmpl_pkg::IDX_W-1:0] j_wide;
   logic [cmpl_pkg::IDX_W-1:0] res_idx_ff;
   logic              res_clamp_ff;
   logic              load_rsp;

   cmpl_ram #(
      .WIDTH (cmpl_pkg::ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({item.position, item.color}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_pos     = ram_rdata[cmpl_pkg::ENTRY_W-1 -: DW];
   assign rd_color   = ram_rdata[cmpl_pkg::COLOR_W-1:0];
   assign waddr_wide = (ADDR_W + cmpl_pkg::IDX_W)'(item.wr_idx);
   assign ram_waddr  = waddr_wide[ADDR_W-1:0];

   // saturate the breakpoint count to [2, MAX_ENTRIES]
   always_comb begin
      priority if (SAT_W'(sample_count) < SAT_W'(2)) begin
         n_wide = SAT_W'(2);
      end else if (SAT_W'(sample_count) > SAT_W'(MAX_ENTRIES)) begin
         n_wide = SAT_W'(MAX_ENTRIES);
      end else begin
         n_wide = SAT_W'(sample_count);
      end
      n_sat = n_wide[CNT_W-1:0];
   end

   // bisection step
   always_comb begin
      sum_cur  = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid_cur  = sum_cur[CNT_W:1];
      ge_cur   = (x_ff >= rd_pos);
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      x_in     = x_ff;
      clamp_in = clamp_ff;
      unique case (state_ff)
         cmpl_pkg::S_IDLE: begin
            x_in = item.sample;
         end
         cmpl_pkg::S_CLAMP: begin
            priority if (x_ff < pfirst_ff) begin
               x_in     = pfirst_ff;
               clamp_in = 1'b1;
            end else if (x_ff > rd_pos) begin
               x_in     = rd_pos;
               clamp_in = 1'b1;
            end else begin
               x_in     = x_ff;
               clamp_in = 1'b0;
            end
            lo_in = '0;
            hi_in = n_ff + CNT_W'(1);
         end
         cmpl_pkg::S_SRCH: begin
            lo_in = ge_cur ? mid_cur : lo_ff;
            hi_in = ge_cur ? hi_ff : mid_cur;
         end
         default: begin
         end
      endcase
      sum_next = {1'b0, lo_in} + {1'b0, hi_in};
      mid_next = sum_next[CNT_W:1];
      gap_next = hi_in - lo_in;
      priority if (x_ff == pfirst_ff) begin
         j_in = '0;
      end else if (x_ff == plast_ff) begin
         j_in = n_ff - CNT_W'(2);
      end else begin
         j_in = lo_in - CNT_W'(1);
      end
   end

   // interval width and offset
   always_comb begin
      degen = (rd_pos <= plo_ff);
      w_in  = rd_pos - plo_ff;
      t_in  = (x_ff > plo_ff) ? (x_ff - plo_ff) : '0;
      if (t_in > w_in) begin
         t_in = w_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cmpl_pkg::S_IDLE: begin
            if (item_valid && item.is_map) begin
               state_in = cmpl_pkg::S_PFIRST;
            end
         end
         cmpl_pkg::S_PFIRST: state_in = cmpl_pkg::S_CLAMP;
         cmpl_pkg::S_CLAMP:  state_in = cmpl_pkg::S_SRCH;
         cmpl_pkg::S_SRCH: begin
            if (gap_next <= CNT_W'(1)) begin
               state_in = cmpl_pkg::S_LO;
            end
         end
         cmpl_pkg::S_LO:     state_in = cmpl_pkg::S_HI;
         cmpl_pkg::S_HI:     state_in = degen ? cmpl_pkg::S_DONE : cmpl_pkg::S_MUL;
         cmpl_pkg::S_MUL:    state_in = cmpl_pkg::S_SUM;
         cmpl_pkg::S_SUM:    state_in = cmpl_pkg::S_DIV;
         cmpl_pkg::S_DIV: begin
            if (div_cnt_ff == '1) begin
               state_in = cmpl_pkg::S_DONE;
            end
         end
         cmpl_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = cmpl_pkg::S_IDLE;
            end
         end
         default: state_in = cmpl_pkg::S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      item_pop  = 1'b0;
      ram_we    = 1'b0;
      ram_raddr = '0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         cmpl_pkg::S_IDLE: begin
            item_pop  = item_valid;
            ram_we    = item_valid && item.wr_en;
            ram_raddr = '0;
         end
         cmpl_pkg::S_PFIRST: ram_raddr = ADDR_W'(n_ff - CNT_W'(1));
         cmpl_pkg::S_CLAMP:  ram_raddr = ADDR_W'(mid_next - CNT_W'(1));
         cmpl_pkg::S_SRCH: begin
            if (gap_next > CNT_W'(1)) begin
               ram_raddr = ADDR_W'(mid_next - CNT_W'(1));
            end else begin
               ram_raddr = ADDR_W'(j_in);
            end
         end
         cmpl_pkg::S_LO:   ram_raddr = ADDR_W'(j_ff + CNT_W'(1));
         cmpl_pkg::S_DONE: load_rsp  = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         acc[c]     = cmpl_pkg::ACC_W'(pa_ff[c]) + cmpl_pkg::ACC_W'(pb_ff[c]) +
                      cmpl_pkg::ACC_W'(w_ff >> 1);
         shifted[c] = {rem_ff[c], quo_ff[c][DW-1]};
         fits[c]    = (shifted[c] >= {1'b0, w_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmpl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == cmpl_pkg::S_DIV) begin
            div_cnt_ff <= div_cnt_ff + cmpl_pkg::DIV_CNT_W'(1);
         end else begin
            div_cnt_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      clamp_ff <= clamp_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      unique case (state_ff)
         cmpl_pkg::S_IDLE: begin
            n_ff <= n_sat;
         end
         cmpl_pkg::S_PFIRST: pfirst_ff <= rd_pos;
         cmpl_pkg::S_CLAMP:  plast_ff  <= rd_pos;
         cmpl_pkg::S_SRCH:   j_ff      <= j_in;
         cmpl_pkg::S_LO: begin
            plo_ff <= rd_pos;
            clo_ff <= rd_color;
         end
         cmpl_pkg::S_HI: begin
            chi_ff <= rd_color;
            w_ff   <= w_in;
            t_ff   <= t_in;
            wt_ff  <= w_in - t_in;
            for (int c = 0; c < NC; c++) begin
               quo_ff[c] <= clo_ff[cmpl_pkg::COLOR_W-1-DW*c -: DW];
            end
         end
         cmpl_pkg::S_MUL: begin
            for (int c = 0; c < NC; c++) begin
               pa_ff[c] <= cmpl_pkg::PROD_W'(clo_ff[cmpl_pkg::COLOR_W-1-DW*c -: DW]) *
                           cmpl_pkg::PROD_W'(wt_ff);
               pb_ff[c] <= cmpl_pkg::PROD_W'(chi_ff[cmpl_pkg::COLOR_W-1-DW*c -: DW]) *
                           cmpl_pkg::PROD_W'(t_ff);
            end
         end
         cmpl_pkg::S_SUM: begin
            for (int c = 0; c < NC; c++) begin
               rem_ff[c] <= acc[c][2*DW-1:DW];
               quo_ff[c] <= acc[c][DW-1:0];
            end
         end
         cmpl_pkg::S_DIV: begin
            for (int c = 0; c < NC; c++) begin
               rem_ff[c] <= fits[c] ? DW'(shifted[c] - {1'b0, w_ff}) : shifted[c][DW-1:0];
               quo_ff[c] <= {quo_ff[c][DW-2:0], fits[c]};
            end
         end
         default: begin
         end
      endcase
   end

   assign j_wide = (CNT_W + cmpl_pkg::IDX_W)'(j_ff);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         for (int c = 0; c < NC; c++) begin
            res_ff[c] <= quo_ff[c];
         end
         res_idx_ff   <= j_wide[cmpl_pkg::IDX_W-1:0];
         res_clamp_ff <= clamp_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_hue        = res_ff[0];
   assign rsp_out_saturation = res_ff[1];
   assign rsp_out_brightness = res_ff[2];
   assign rsp_interval_index = res_idx_ff;
   assign rsp_was_clamped    = res_clamp_ff;

   assert property (@(posedge clock)
      $past(reset) |-> (state_ff == cmpl_pkg::S_IDLE))
      else $error("back end not idle after reset");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cmpl_pkg::S_SRCH) |-> (hi_ff > lo_ff + CNT_W'(1)))
      else $error("bisection running on a closed range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cmpl_pkg::S_LO) |-> (j_ff <= n_ff - CNT_W'(2)))
      else $error("interval index beyond last interval");

   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == cmpl_pkg::S_DIV && state_ff == cmpl_pkg::S_DONE) |->
      ($past(div_cnt_ff) == '1))
      else $error("division left early");

endmodule

// File: src/colormap_piecewise_linear_unit.sv
// colormap piecewise-linear unit, top level
// depends on cmpl_pkg, cmpl_front, cmpl_back and cmpl_ram
//
// The req channel carries two kinds of transaction. A write (opcode 0) stores
// one breakpoint: position and hue, saturation, brightness. A map (opcode 1)
// clamps the sample to the table range, finds its interval by bisection
// over the first sample_count breakpoints and interpolates each channel,
// rounded to nearest. Each map gives one rsp transaction; writes give none.
// csr_write_enable loads sample_count (reset value 2); the user must assert
// it only while idle, the block does not enforce this. A two-entry queue
// decouples the request side from the back end. Writes finish in the idle
// state. A map reads the first and last breakpoints, bisects with one table
// read per cycle, reads the interval ends, then multiplies, sums and runs a
// restoring divider; a zero-width interval skips the multiply, sum and
// division. Map transactions are handled one at a time: no new item is taken
// until the current map is finished. The result sits in an output register,
// so the back end starts the next transaction while rsp waits; if rsp_ready
// stays low it stalls only when a second result is finished. Reset clears
// control state but not the table, which must be written before use.
`timescale 1ns / 1ps

module colormap_piecewise_linear_unit #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [cmpl_pkg::CFG_W-1:0]  csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [cmpl_pkg::IDX_W-1:0]  req_entry_index,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_position,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_hue,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_saturation,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_brightness,
   input  logic [cmpl_pkg::DATA_W-1:0] req_sample_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cmpl_pkg::DATA_W-1:0] rsp_out_hue,
   output logic [cmpl_pkg::DATA_W-1:0] rsp_out_saturation,
   output logic [cmpl_pkg::DATA_W-1:0] rsp_out_brightness,
   output logic [cmpl_pkg::IDX_W-1:0]  rsp_interval_index,
   output logic                        rsp_was_clamped
);

   logic [cmpl_pkg::CFG_W-1:0] sample_count_ff;
   logic                       item_valid;
   logic                       item_pop;
   cmpl_pkg::item_type         item;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= cmpl_pkg::SAMPLE_COUNT_RESET;
      end else if (csr_write_enable) begin
         sample_count_ff <= csr_write_data;
      end
   end

   cmpl_front #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_entry_index      (req_entry_index),
      .req_entry_position   (req_entry_position),
      .req_entry_hue        (req_entry_hue),
      .req_entry_saturation (req_entry_saturation),
      .req_entry_brightness (req_entry_brightness),
      .req_sample_value     (req_sample_value),
      .item_valid           (item_valid),
      .item                 (item),
      .item_pop             (item_pop)
   );

   cmpl_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .sample_count       (sample_count_ff),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_hue        (rsp_out_hue),
      .rsp_out_saturation (rsp_out_saturation),
      .rsp_out_brightness (rsp_out_brightness),
      .rsp_interval_index (rsp_interval_index),
      .rsp_was_clamped    (rsp_was_clamped)
   );

endmodule

// File: tb/colormap_piecewise_linear_unit_checker.sv
// colormap piecewise-linear unit checker: tracks the breakpoint table and sample_count,
// predicts each map result and compares it with the rsp channel
// depends on cmpl_pkg only
`timescale 1ns / 1ps

module colormap_piecewise_linear_unit_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [cmpl_pkg::CFG_W-1:0]  csr_write_data,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [cmpl_pkg::IDX_W-1:0]  req_entry_index,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_position,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_hue,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_saturation,
   input  logic [cmpl_pkg::DATA_W-1:0] req_entry_brightness,
   input  logic [cmpl_pkg::DATA_W-1:0] req_sample_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [cmpl_pkg::DATA_W-1:0] rsp_out_hue,
   input  logic [cmpl_pkg::DATA_W-1:0] rsp_out_saturation,
   input  logic [cmpl_pkg::DATA_W-1:0] rsp_out_brightness,
   input  logic [cmpl_pkg::IDX_W-1:0]  rsp_interval_index,
   input  logic                        rsp_was_clamped,
   output int                          fail_count,
   output int                          colors_pending
);

   typedef struct {
      logic [cmpl_pkg::DATA_W-1:0] hue;
      logic [cmpl_pkg::DATA_W-1:0] sat;
      logic [cmpl_pkg::DATA_W-1:0] bri;
      logic [cmpl_pkg::IDX_W-1:0]  seg;
      logic                        clamped;
   } color_type;

   logic [cmpl_pkg::DATA_W-1:0] bp_pos [16];
   logic [cmpl_pkg::DATA_W-1:0] bp_hsv [16][3];
   logic [cmpl_pkg::CFG_W-1:0]  active_count;
   color_type                   expected_colors [$];

   function automatic int find_segment(int n, int x);
      int lo, hi, mid;
      lo = 0;
      hi = n + 1;
      while (hi - lo > 1) begin
         mid = (hi + lo) >> 1;
         if (x >= bp_pos[mid-1]) lo = mid;
         else hi = mid;
      end
      if (x == bp_pos[0]) return 0;
      if (x == bp_pos[n-1]) return n - 2;
      return lo - 1;
   endfunction

   function automatic logic [cmpl_pkg::DATA_W-1:0] mix_channel(longint c0, longint c1,
                                                               longint t, longint w);
      return cmpl_pkg::DATA_W'((c0 * (w - t) + c1 * t + w / 2) / w);
   endfunction

   function automatic color_type map_sample(logic [cmpl_pkg::DATA_W-1:0] sample);
      color_type r;
      int n, x, j, p0, p1, w, t;
      n = active_count;
      if (n < 2) n = 2;
      if (n > 16) n = 16;
      x = sample;
      r.clamped = 1'b0;
      if (x < bp_pos[0]) begin
         x = bp_pos[0];
         r.clamped = 1'b1;
      end else if (x > bp_pos[n-1]) begin
         x = bp_pos[n-1];
         r.clamped = 1'b1;
      end
      j = find_segment(n, x);
      p0 = bp_pos[j];
      p1 = bp_pos[j+1];
      if (p1 <= p0) begin
         r.hue = bp_hsv[j][0];
         r.sat = bp_hsv[j][1];
         r.bri = bp_hsv[j][2];
      end else begin
         w = p1 - p0;
         t = (x > p0) ? x - p0 : 0;
         if (t > w) t = w;
         r.hue = mix_channel(bp_hsv[j][0], bp_hsv[j+1][0], t, w);
         r.sat = mix_channel(bp_hsv[j][1], bp_hsv[j+1][1], t, w);
         r.bri = mix_channel(bp_hsv[j][2], bp_hsv[j+1][2], t, w);
      end
      r.seg = cmpl_pkg::IDX_W'(j);
      return r;
   endfunction

   initial begin
      fail_count = 0;
      colors_pending = 0;
      active_count = cmpl_pkg::SAMPLE_COUNT_RESET;
   end

   always @(posedge clock) begin
      color_type e;
      if (reset) begin
         active_count = cmpl_pkg::SAMPLE_COUNT_RESET;
      end else begin
         if (csr_write_enable) active_count = csr_write_data;
         if (req_valid && req_ready) begin
            if (req_opcode == cmpl_pkg::OP_WRITE) begin
               bp_pos[req_entry_index] = req_entry_position;
               bp_hsv[req_entry_index][0] = req_entry_hue;
               bp_hsv[req_entry_index][1] = req_entry_saturation;
               bp_hsv[req_entry_index][2] = req_entry_brightness;
            end else begin
               expected_colors.push_back(map_sample(req_sample_value));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               $error("unexpected rsp transaction");
               fail_count++;
            end else begin
               e = expected_colors.pop_front();
               if (rsp_out_hue !== e.hue) begin
                  $error("out_hue expected %0d actual %0d", e.hue, rsp_out_hue);
                  fail_count++;
               end
               if (rsp_out_saturation !== e.sat) begin
                  $error("out_saturation expected %0d actual %0d", e.sat, rsp_out_saturation);
                  fail_count++;
               end
               if (rsp_out_brightness !== e.bri) begin
                  $error("out_brightness expected %0d actual %0d", e.bri, rsp_out_brightness);
                  fail_count++;
               end
               if (rsp_interval_index !== e.seg) begin
                  $error("interval_index expected %0d actual %0d", e.seg, rsp_interval_index);
                  fail_count++;
               end
               if (rsp_was_clamped !== e.clamped) begin
                  $error("was_clamped expected %0d actual %0d", e.clamped, rsp_was_clamped);
                  fail_count++;
               end
            end
         end
      end
      colors_pending = expected_colors.size();
   end

endmodule

// File: tb/colormap_piecewise_linear_unit_tb.sv
// colormap piecewise-linear unit testbench top: clock, reset, stimulus and verdict
// depends on cmpl_pkg, colormap_piecewise_linear_unit and its checker
`timescale 1ns / 1ps

module colormap_piecewise_linear_unit_tb;

   localparam int LIMIT_CYCLES = 600000;
   localparam int SETTLE_CYCLES = 80;
   localparam logic [cmpl_pkg::DATA_W-1:0] ONE = 16'd32768;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [cmpl_pkg::CFG_W-1:0]    csr_write_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_opcode = cmpl_pkg::OP_WRITE;
   logic [cmpl_pkg::IDX_W-1:0]    req_entry_index = '0;
   logic [cmpl_pkg::DATA_W-1:0]   req_entry_position = '0;
   logic [cmpl_pkg::DATA_W-1:0]   req_entry_hue = '0;
   logic [cmpl_pkg::DATA_W-1:0]   req_entry_saturation = '0;
   logic [cmpl_pkg::DATA_W-1:0]   req_entry_brightness = '0;
   logic [cmpl_pkg::DATA_W-1:0]   req_sample_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [cmpl_pkg::DATA_W-1:0]   rsp_out_hue;
   logic [cmpl_pkg::DATA_W-1:0]   rsp_out_saturation;
   logic [cmpl_pkg::DATA_W-1:0]   rsp_out_brightness;
   logic [cmpl_pkg::IDX_W-1:0]    rsp_interval_index;
   logic                          rsp_was_clamped;
   int                            fail_count;
   int                            colors_pending;
   int                            cycle_count = 0;
   bit                            quiet = 1'b0;
   logic [cmpl_pkg::DATA_W-1:0]   table_pos [16];

   always #5 clock = ~clock;

   colormap_piecewise_linear_unit uut (.*);
   colormap_piecewise_linear_unit_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("colormap_piecewise_linear_unit test failed");
         $finish;
      end
   end

   // rsp back-pressure
   initial begin
      @(negedge clock);
      rsp_ready <= 1'b1;
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   task automatic send(logic op, logic [cmpl_pkg::IDX_W-1:0] idx,
                       logic [cmpl_pkg::DATA_W-1:0] pos, logic [cmpl_pkg::DATA_W-1:0] h,
                       logic [cmpl_pkg::DATA_W-1:0] s, logic [cmpl_pkg::DATA_W-1:0] b,
                       logic [cmpl_pkg::DATA_W-1:0] x);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entry_index <= idx;
      req_entry_position <= pos;
      req_entry_hue <= h;
      req_entry_saturation <= s;
      req_entry_brightness <= b;
      req_sample_value <= x;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_entry(int idx, logic [cmpl_pkg::DATA_W-1:0] pos);
      table_pos[idx] = pos;
      send(cmpl_pkg::OP_WRITE, cmpl_pkg::IDX_W'(idx), pos,
           cmpl_pkg::DATA_W'($urandom_range(0, ONE)),
           cmpl_pkg::DATA_W'($urandom_range(0, ONE)),
           cmpl_pkg::DATA_W'($urandom_range(0, ONE)),
           cmpl_pkg::DATA_W'($urandom));
   endtask

   task automatic map(logic [cmpl_pkg::DATA_W-1:0] x);
      send(cmpl_pkg::OP_MAP, cmpl_pkg::IDX_W'($urandom), cmpl_pkg::DATA_W'($urandom),
           cmpl_pkg::DATA_W'($urandom), cmpl_pkg::DATA_W'($urandom),
           cmpl_pkg::DATA_W'($urandom), x);
   endtask

   task automatic set_count(logic [cmpl_pkg::CFG_W-1:0] value);
      req_valid <= 1'b0;
      @(negedge clock);
      while (colors_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_table();
      logic [cmpl_pkg::DATA_W-1:0] vals [$];
      int k;
      vals = {};
      for (int i = 0; i < 16; i++) vals.push_back(cmpl_pkg::DATA_W'($urandom_range(0, ONE)));
      vals.sort();
      if ($urandom_range(0, 3) == 0) begin
         k = $urandom_range(0, 14);
         vals[k+1] = vals[k];
      end
      if ($urandom_range(0, 5) == 0) begin
         k = $urandom_range(0, 14);
         vals[k] = vals[k+1] + 16'd1;
      end
      for (int i = 0; i < 16; i++) write_entry(i, vals[i]);
   endtask

   initial begin
      logic [cmpl_pkg::CFG_W-1:0] counts [8];
      int r;
      counts = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd9, 5'd3, 5'd2};
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extreme colors, clamp on both sides, exact breakpoints, zero width
      for (int i = 0; i < 16; i++) begin
         table_pos[i] = cmpl_pkg::DATA_W'(1000 + i * 2000);
         send(cmpl_pkg::OP_WRITE, cmpl_pkg::IDX_W'(i), table_pos[i], (i % 2) ? ONE : 16'd0,
              (i % 2) ? 16'd0 : ONE, cmpl_pkg::DATA_W'(i * 2048), 16'd0);
      end
      map(16'd0);
      map(ONE);
      map(16'd1000);
      map(16'd3000);
      map(16'd2001);
      write_entry(1, 16'd1000);
      map(16'd1000);
      map(16'd1500);

      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7) quiet = 1'b1;
         set_count(counts[ph]);
         load_table();
         for (int it = 0; it < 120; it++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               write_entry($urandom_range(0, 15), cmpl_pkg::DATA_W'($urandom_range(0, ONE)));
            else if (r < 30)
               map(table_pos[$urandom_range(0, 15)] +
                   cmpl_pkg::DATA_W'($urandom_range(0, 2)) - 16'd1);
            else if (r < 35)
               map($urandom_range(0, 1) ? ONE : 16'd0);
            else
               map(cmpl_pkg::DATA_W'($urandom_range(0, ONE)));
         end
      end

      req_valid <= 1'b0;
      while (colors_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && colors_pending == 0)
         $display("colormap_piecewise_linear_unit test passed");
      else
         $display("colormap_piecewise_linear_unit test failed");
      $finish;
   end

endmodule

// File: files.f
src/cmpl_pkg.sv
src/cmpl_ram.sv
src/cmpl_front.sv
src/cmpl_back.sv
src/colormap_piecewise_linear_unit.sv
tb/colormap_piecewise_linear_unit_checker.sv
tb/colormap_piecewise_linear_unit_tb.sv
